>>> rtl/linear_interp_resampler_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear interpolation resampler
// Shared concurrent assertion forms, clocked on i_clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH

// Same-cycle implication: whenever pre holds, post holds too.
`define LIR_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |-> (post)) else $error(msg);

// Next-cycle implication: whenever pre holds, post holds in the cycle after.
`define LIR_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// Resampler package
// Fixed widths, register map, controller states and the divider structs.
// ----------------------------------------------------------------------------
package lir_pkg;

    // Rate registers and phase state
    localparam int RATE_W     = 18;
    localparam int CC_W       = 3;
    localparam int FRAC_BITS  = 15;
    localparam int DIV_STEP_W = 5;

    // Result counting per input sample
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = 7;
    localparam int CHN_W       = 4;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_IN_RATE  = 2'd0;
    localparam logic [1:0] REG_OUT_RATE = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    localparam logic [RATE_W-1:0] IN_RATE_RST  = 18'd16000;
    localparam logic [RATE_W-1:0] OUT_RATE_RST = 18'd48000;
    localparam logic [CC_W-1:0]   CHANNELS_RST = 3'd1;

    localparam logic [RATE_W-1:0] SKIP_MAX = {RATE_W{1'b1}};

    typedef struct packed {
        logic [RATE_W-1:0] in_rate;
        logic [RATE_W-1:0] out_rate;
        logic [CC_W-1:0]   channel_count;
    } t_cfg;

    // Divider request: the partial remainder starts at init_p and the
    // dividend bits shift in MSB first for the given number of steps.
    typedef struct packed {
        logic                  start;
        logic [RATE_W-1:0]     init_p;
        logic [RATE_W:0]       dividend;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [RATE_W:0]   quot;
        logic [RATE_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_FOLD,
        S_SCAN,
        S_TDIV,
        S_MUL,
        S_EMIT,
        S_ADV,
        S_FINISH
    } t_state;

endpackage

>>> rtl/lir_if.sv
// ----------------------------------------------------------------------------
// Resampler stream interfaces
// Valid/ready channels for input samples and resampled results.
// ----------------------------------------------------------------------------
interface lir_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          last_sample;

    modport source (output valid, sample_in, last_sample, input ready);
    modport sink   (input valid, sample_in, last_sample, output ready);
endinterface

interface lir_out_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int CH_W        = 2
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [CH_W-1:0]               channel_index;
    logic                          last_of_run;
    logic                          block_end;
    logic                          ratio_error;

    modport source (output valid, sample_out, channel_index, last_of_run,
                    block_end, ratio_error, input ready);
    modport sink   (input valid, sample_out, channel_index, last_of_run,
                    block_end, ratio_error, output ready);
endinterface

>>> rtl/lir_cfg.sv
// ----------------------------------------------------------------------------
// Resampler configuration registers
// APB-style register file for the two rates and the channel count.
// ----------------------------------------------------------------------------
module lir_cfg import lir_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [RATE_W-1:0] r_in_rate;
    logic [RATE_W-1:0] r_out_rate;
    logic [CC_W-1:0]   r_channels;
    logic              w_wr;
    logic [1:0]        w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rate  <= IN_RATE_RST;
            r_out_rate <= OUT_RATE_RST;
            r_channels <= CHANNELS_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_IN_RATE:  r_in_rate  <= pwdata[RATE_W-1:0];
                REG_OUT_RATE: r_out_rate <= pwdata[RATE_W-1:0];
                REG_CHANNELS: r_channels <= pwdata[CC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            REG_IN_RATE:  prdata = PDATA_W'(r_in_rate);
            REG_OUT_RATE: prdata = PDATA_W'(r_out_rate);
            REG_CHANNELS: prdata = PDATA_W'(r_channels);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = '{in_rate: r_in_rate, out_rate: r_out_rate,
                     channel_count: r_channels};

endmodule

>>> rtl/lir_div.sv
// ----------------------------------------------------------------------------
// Resampler bit-serial divider
// Restoring division by out_rate, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lir_div import lir_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    input  logic [RATE_W-1:0] i_divisor,
    output t_div_rsp          o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [RATE_W-1:0]     r_p;
    logic [RATE_W:0]       r_d;
    logic [RATE_W:0]       r_q;
    logic [RATE_W:0]       w_trial;
    logic [RATE_W:0]       w_diff;
    logic                  w_fit;

    // Shift one dividend bit into the partial remainder and try a subtract
    assign w_trial = {r_p, r_d[RATE_W]};
    assign w_fit   = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder, dividend and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_p <= i_req.init_p;
            r_d <= i_req.dividend;
            r_q <= '0;
        end else if (r_busy) begin
            r_p <= w_fit ? w_diff[RATE_W-1:0] : w_trial[RATE_W-1:0];
            r_d <= {r_d[RATE_W-1:0], 1'b0};
            r_q <= {r_q[RATE_W-1:0], w_fit};
        end
    end

    assign o_rsp = '{done: r_done, quot: r_q, rem: r_p};

endmodule

>>> rtl/lir_interp.sv
// ----------------------------------------------------------------------------
// Resampler interpolator
// Serial shift-add product of (b - a) by the phase fraction, then a + floor
// of the scaled product, saturated to the sample range.
// ----------------------------------------------------------------------------
module lir_interp import lir_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_a,
    input  logic signed [SAMPLE_BITS-1:0] i_b,
    input  logic [FRAC_BITS-1:0]          i_t,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_value
);

    localparam int DW    = SAMPLE_BITS + 1;
    localparam int PW    = DW + FRAC_BITS;
    localparam int SW    = SAMPLE_BITS + 2;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    localparam logic signed [SW-1:0] HI = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] LO = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

    logic                          r_busy;
    logic                          r_fin;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic signed [DW-1:0]          r_diff;
    logic [FRAC_BITS-1:0]          r_t;
    logic signed [PW-1:0]          r_acc;
    logic signed [SAMPLE_BITS-1:0] r_a;
    logic signed [SAMPLE_BITS-1:0] r_value;
    logic signed [PW-1:0]          w_addend;
    logic signed [SW-1:0]          w_sum;

    assign w_addend = r_t[FRAC_BITS-1] ? {{FRAC_BITS{r_diff[DW-1]}}, r_diff} : '0;
    // Arithmetic shift of the product gives the floor
    assign w_sum = {{2{r_a[SAMPLE_BITS-1]}}, r_a}
                 + {r_acc[PW-1], r_acc[PW-1:FRAC_BITS]};

    // Sequence: multiply steps, then an add-and-clamp step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: MSB-first shift-add over the fraction bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_diff <= {i_b[SAMPLE_BITS-1], i_b} - {i_a[SAMPLE_BITS-1], i_a};
            r_a    <= i_a;
            r_t    <= i_t;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc <<< 1) + w_addend;
            r_t   <= {r_t[FRAC_BITS-2:0], 1'b0};
        end else if (r_fin) begin
            if (w_sum > HI) begin
                r_value <= HI[SAMPLE_BITS-1:0];
            end else if (w_sum < LO) begin
                r_value <= LO[SAMPLE_BITS-1:0];
            end else begin
                r_value <= w_sum[SAMPLE_BITS-1:0];
            end
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

>>> rtl/linear_interp_resampler_core.sv
// ----------------------------------------------------------------------------
// Linear interpolation resampler core
// Converts a block of mono samples from in_rate to out_rate by linear
// interpolation and sends each frame once per output channel.
//
//   Channel   Dir   Handshake          Carries
//   i_in      in    valid/ready        sample_in, last_sample
//   o_out     out   valid/ready        sample_out, channel_index,
//                                      last_of_run, block_end, ratio_error
//   cfg       in    APB write/read     in_rate, out_rate, channel_count
//
// One sample at a time: i_in.ready is high only while the controller idles.
// An item may first fold the remainder after a rate change; each frame then
// passes a scan step, the fraction division, the multiply and clamp, one
// emit per channel and the phase advance; held frames after the last sample
// skip the division and the multiply.
// Reset is synchronous; no clearing pass is needed.
// A full output register under a stalled o_out holds emit, error and finish.
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_core_defines.svh"

module linear_interp_resampler_core import lir_pkg::*; #(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_UPSAMPLE = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lir_in_if.sink             i_in,
    lir_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int UP_W = RATE_W + 5;

    t_cfg     w_cfg;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic                          w_mul_start;
    logic                          w_mul_done;
    logic signed [SAMPLE_BITS-1:0] w_mul_value;

    t_state r_state, n_state;

    logic signed [SAMPLE_BITS-1:0] r_prev, n_prev;
    logic                          r_have_prev, n_have_prev;
    logic [RATE_W-1:0]             r_rem, n_rem;
    logic [RATE_W-1:0]             r_skip, n_skip;
    logic signed [SAMPLE_BITS-1:0] r_cur, n_cur;
    logic                          r_last, n_last;
    logic                          r_tail, n_tail;
    logic [RES_CNT_W-1:0]          r_n, n_n;
    logic [CHN_W-1:0]              r_chans, n_chans;
    logic [CH_W-1:0]               r_ch, n_ch;
    logic signed [SAMPLE_BITS-1:0] r_val, n_val;

    logic                          r_pend_valid, n_pend_valid;
    logic signed [SAMPLE_BITS-1:0] r_pend_sample, n_pend_sample;
    logic [CH_W-1:0]               r_pend_ch, n_pend_ch;

    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample, n_out_sample;
    logic [CH_W-1:0]               r_out_ch, n_out_ch;
    logic                          r_out_lor, n_out_lor;
    logic                          r_out_be, n_out_be;
    logic                          r_out_err, n_out_err;

    logic             w_out_free;
    logic             w_bad_ratio;
    logic             w_room;
    logic [UP_W-1:0]  w_up_limit;
    logic [CHN_W-1:0] w_chans;
    logic [CHN_W-1:0] w_cc;
    logic [RATE_W:0]  w_adv_sum;

    // Saturating add of a quotient onto the skip count
    function automatic logic [RATE_W-1:0] sat_skip(input logic [RATE_W-1:0] skip,
                                                   input logic [RATE_W:0]   quot);
        logic [RATE_W+1:0] sum;
        sum = {2'b00, skip} + {1'b0, quot};
        return (sum > {2'b00, SKIP_MAX}) ? SKIP_MAX : sum[RATE_W-1:0];
    endfunction

    lir_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lir_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_div_req),
        .i_divisor (w_cfg.out_rate),
        .o_rsp     (w_div_rsp)
    );

    lir_interp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_prev),
        .i_b     (r_cur),
        .i_t     (w_div_rsp.quot[FRAC_BITS-1:0]),
        .o_done  (w_mul_done),
        .o_value (w_mul_value)
    );

    // Rate check, channel clamp and per-sample result room
    assign w_up_limit  = UP_W'(w_cfg.in_rate) * UP_W'(MAX_UPSAMPLE);
    assign w_bad_ratio = (w_cfg.in_rate == '0) || (w_cfg.out_rate == '0)
                      || (UP_W'(w_cfg.out_rate) > w_up_limit);
    assign w_cc        = CHN_W'(w_cfg.channel_count);
    assign w_chans     = (w_cc == '0) ? CHN_W'(1)
                       : (w_cc > CHN_W'(MAX_CHANNELS)) ? CHN_W'(MAX_CHANNELS) : w_cc;
    assign w_room      = ({1'b0, r_n} + (RES_CNT_W+1)'(r_chans))
                      <= (RES_CNT_W+1)'(MAX_RESULTS);
    assign w_adv_sum   = {1'b0, r_rem} + {1'b0, w_cfg.in_rate};
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign i_in.ready = (r_state == S_IDLE);

    // Drive the result port from the output register
    assign o_out.valid         = r_out_valid;
    assign o_out.sample_out    = r_out_sample;
    assign o_out.channel_index = r_out_ch;
    assign o_out.last_of_run   = r_out_lor;
    assign o_out.block_end     = r_out_be;
    assign o_out.ratio_error   = r_out_err;

    // State register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev       <= '0;
            r_have_prev  <= 1'b0;
            r_rem        <= '0;
            r_skip       <= '0;
            r_tail       <= 1'b0;
            r_n          <= '0;
            r_ch         <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev       <= n_prev;
            r_have_prev  <= n_have_prev;
            r_rem        <= n_rem;
            r_skip       <= n_skip;
            r_tail       <= n_tail;
            r_n          <= n_n;
            r_ch         <= n_ch;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur         <= n_cur;
        r_last        <= n_last;
        r_chans       <= n_chans;
        r_val         <= n_val;
        r_pend_sample <= n_pend_sample;
        r_pend_ch     <= n_pend_ch;
        r_out_sample  <= n_out_sample;
        r_out_ch      <= n_out_ch;
        r_out_lor     <= n_out_lor;
        r_out_be      <= n_out_be;
        r_out_err     <= n_out_err;
    end

    // Next state and outputs
    always_comb begin
        n_state       = r_state;
        n_prev        = r_prev;
        n_have_prev   = r_have_prev;
        n_rem         = r_rem;
        n_skip        = r_skip;
        n_cur         = r_cur;
        n_last        = r_last;
        n_tail        = r_tail;
        n_n           = r_n;
        n_chans       = r_chans;
        n_ch          = r_ch;
        n_val         = r_val;
        n_pend_valid  = r_pend_valid;
        n_pend_sample = r_pend_sample;
        n_pend_ch     = r_pend_ch;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_sample  = r_out_sample;
        n_out_ch      = r_out_ch;
        n_out_lor     = r_out_lor;
        n_out_be      = r_out_be;
        n_out_err     = r_out_err;
        w_div_req     = '{start: 1'b0, init_p: '0, dividend: '0, steps: '0};
        w_mul_start   = 1'b0;

        unique case (r_state)
            // Take a request and decide how to start it
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cur   = i_in.sample_in;
                    n_last  = i_in.last_sample;
                    n_chans = w_chans;
                    n_tail  = 1'b0;
                    n_n     = '0;
                    n_ch    = '0;
                    if (w_bad_ratio) begin
                        n_state = S_ERR;
                    end else if (r_rem >= w_cfg.out_rate) begin
                        w_div_req = '{start: 1'b1, init_p: '0,
                                      dividend: {r_rem, 1'b0},
                                      steps: DIV_STEP_W'(RATE_W)};
                        n_state = S_FOLD;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            // Unusable rates: one flagged zero result, drop the state
            S_ERR: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = '0;
                    n_out_ch     = '0;
                    n_out_lor    = 1'b1;
                    n_out_be     = r_last;
                    n_out_err    = 1'b1;
                    n_prev       = '0;
                    n_have_prev  = 1'b0;
                    n_rem        = '0;
                    n_skip       = '0;
                    n_state      = S_IDLE;
                end
            end

            // Fold an oversized remainder into the skip count
            S_FOLD: begin
                if (w_div_rsp.done) begin
                    n_rem   = w_div_rsp.rem;
                    n_skip  = sat_skip(r_skip, w_div_rsp.quot);
                    n_state = S_SCAN;
                end
            end

            // Pick the next frame, or close the current phase
            S_SCAN: begin
                if (!r_tail) begin
                    if (r_have_prev && r_skip == '0 && w_room) begin
                        w_div_req = '{start: 1'b1, init_p: r_rem, dividend: '0,
                                      steps: DIV_STEP_W'(FRAC_BITS)};
                        n_state = S_TDIV;
                    end else begin
                        if (r_have_prev && r_skip != '0) begin
                            n_skip = r_skip - 1'b1;
                        end
                        n_prev      = r_cur;
                        n_have_prev = 1'b1;
                        if (r_last) begin
                            n_tail = 1'b1;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                end else begin
                    if (r_skip == '0 && w_room) begin
                        n_val   = r_cur;
                        n_ch    = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_prev      = '0;
                        n_have_prev = 1'b0;
                        n_rem       = '0;
                        n_skip      = '0;
                        n_state     = S_FINISH;
                    end
                end
            end

            // Fraction ready: start the interpolation product
            S_TDIV: begin
                if (w_div_rsp.done) begin
                    w_mul_start = 1'b1;
                    n_state     = S_MUL;
                end
            end

            S_MUL: begin
                if (w_mul_done) begin
                    n_val   = w_mul_value;
                    n_ch    = '0;
                    n_state = S_EMIT;
                end
            end

            // Send one copy per channel through the pending stage
            S_EMIT: begin
                if (w_out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid  = 1'b1;
                        n_out_sample = r_pend_sample;
                        n_out_ch     = r_pend_ch;
                        n_out_lor    = 1'b0;
                        n_out_be     = 1'b0;
                        n_out_err    = 1'b0;
                    end
                    n_pend_valid  = 1'b1;
                    n_pend_sample = r_val;
                    n_pend_ch     = r_ch;
                    n_n           = r_n + 1'b1;
                    if (CHN_W'(r_ch) == r_chans - 1'b1) begin
                        w_div_req = '{start: 1'b1, init_p: '0, dividend: w_adv_sum,
                                      steps: DIV_STEP_W'(RATE_W + 1)};
                        n_state = S_ADV;
                    end else begin
                        n_ch = r_ch + 1'b1;
                    end
                end
            end

            // Advance the frame position by in_rate / out_rate
            S_ADV: begin
                if (w_div_rsp.done) begin
                    n_rem   = w_div_rsp.rem;
                    n_skip  = sat_skip(r_skip, w_div_rsp.quot);
                    n_state = S_SCAN;
                end
            end

            // Release the final result with its end marks
            S_FINISH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_pend_sample;
                    n_out_ch     = r_pend_ch;
                    n_out_lor    = 1'b1;
                    n_out_be     = r_last;
                    n_out_err    = 1'b0;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Checks on controller behavior
    `LIR_ASSERT_IMPL(a_tdiv_rem_below, r_state == S_TDIV, r_rem < w_cfg.out_rate, "rem too large")
    `LIR_ASSERT_IMPL(a_result_cap, 1'b1, r_n <= RES_CNT_W'(MAX_RESULTS), "result count above cap")
    `LIR_ASSERT_IMPL(a_idle_no_pend, r_state == S_IDLE, !r_pend_valid, "pending result at idle")
    `LIR_ASSERT_IMPL(a_err_result, r_out_valid && r_out_err, r_out_lor && r_out_sample == '0, "bad flag")
    `LIR_ASSERT_NEXT(a_emit_fills_pend, r_state == S_EMIT && w_out_free, r_pend_valid, "copy not held")

endmodule

>>> verif/tb_linear_interp_resampler_core.sv
// ----------------------------------------------------------------------------
// Testbench for the linear interpolation resampler core
// Drives sample blocks through the valid/ready input under several rate and
// channel settings, writes the settings over APB while the core is idle, and
// checks every result against a scoreboard that predicts each frame copy.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lir_pkg::*;

    localparam int MAX_CHANNELS   = 4;
    localparam int MAX_UPSAMPLE   = 8;
    localparam int RATE_MAX       = (1 << RATE_W) - 1;
    localparam int LATENCY_WAIT   = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TOTAL_ITEMS    = 420;
    localparam int QUIET_ITEMS    = 60;

    // One result as it leaves the core
    typedef struct packed {
        logic signed [15:0] smp;
        logic [1:0]         chan;
        logic               last_of_run;
        logic               block_end;
        logic               ratio_error;
    } t_frame_res;

    // Predicts the frame copies of each accepted sample and checks results
    class resample_scoreboard;
        logic [RATE_W-1:0]  in_rate;
        logic [RATE_W-1:0]  out_rate;
        logic [CC_W-1:0]    chan_cfg;
        logic signed [15:0] held_smp;
        bit                 held_valid;
        logic [RATE_W-1:0]  phase_rem;
        logic [RATE_W-1:0]  skip_cnt;
        t_frame_res         expected_frames[$];
        int                 errors;

        function new();
            in_rate  = IN_RATE_RST;
            out_rate = OUT_RATE_RST;
            chan_cfg = CHANNELS_RST;
            errors   = 0;
            clear_phase();
        endfunction

        task report(string msg);
            $display("[%0t] scoreboard error: %s", $time, msg);
            errors++;
        endtask

        function void apply_cfg(logic [1:0] idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_IN_RATE:  in_rate  = val[RATE_W-1:0];
                REG_OUT_RATE: out_rate = val[RATE_W-1:0];
                REG_CHANNELS: chan_cfg = val[CC_W-1:0];
                default: ;
            endcase
        endfunction

        function void clear_phase();
            held_smp   = '0;
            held_valid = 1'b0;
            phase_rem  = '0;
            skip_cnt   = '0;
        endfunction

        function void add_skip(longint extra);
            longint whole;
            whole = longint'(skip_cnt) + extra;
            skip_cnt = (whole > longint'(SKIP_MAX)) ? SKIP_MAX : whole[RATE_W-1:0];
        endfunction

        // Value between a and b at the current phase, floored and clamped
        function logic signed [15:0] lerp(logic signed [15:0] a, logic signed [15:0] b);
            longint frac;
            longint prod;
            longint v;
            frac = (longint'(phase_rem) << FRAC_BITS) / longint'(out_rate);
            prod = (longint'(b) - longint'(a)) * frac;
            v = longint'(a) + (prod >>> FRAC_BITS);
            if (v > 32767)
                v = 32767;
            else if (v < -32768)
                v = -32768;
            return v[15:0];
        endfunction

        // Step the frame position by one output period
        function void advance_phase();
            longint acc;
            acc = longint'(phase_rem) + longint'(in_rate);
            phase_rem = RATE_W'(acc % longint'(out_rate));
            add_skip(acc / longint'(out_rate));
        endfunction

        function void push_frame(logic signed [15:0] v, int chans);
            t_frame_res e;
            for (int c = 0; c < chans; c++) begin
                e = '0;
                e.smp = v;
                e.chan = c[1:0];
                expected_frames.push_back(e);
            end
        endfunction

        // Work out the frame copies that one accepted sample causes
        function void note_sample(logic signed [15:0] smp, bit is_last);
            int chans;
            int made;
            t_frame_res e;
            made  = 0;
            chans = int'(chan_cfg);
            if (chans < 1)
                chans = 1;
            if (chans > MAX_CHANNELS)
                chans = MAX_CHANNELS;

            // Unusable rates: one flagged result, state clears
            if (in_rate == 0 || out_rate == 0 ||
                longint'(out_rate) > MAX_UPSAMPLE * longint'(in_rate)) begin
                e = '0;
                e.last_of_run = 1'b1;
                e.block_end = is_last;
                e.ratio_error = 1'b1;
                expected_frames.push_back(e);
                clear_phase();
                return;
            end

            // Fold a remainder left over from a larger out_rate
            if (phase_rem >= out_rate) begin
                add_skip(longint'(phase_rem) / longint'(out_rate));
                phase_rem = RATE_W'(longint'(phase_rem) % longint'(out_rate));
            end

            // Interpolated frames between the held sample and this one
            if (held_valid) begin
                while (skip_cnt == 0 && made + chans <= MAX_RESULTS) begin
                    push_frame(lerp(held_smp, smp), chans);
                    made += chans;
                    advance_phase();
                end
                if (skip_cnt > 0)
                    skip_cnt--;
            end
            held_smp   = smp;
            held_valid = 1'b1;

            // Frames past the last sample hold its value
            if (is_last) begin
                while (skip_cnt == 0 && made + chans <= MAX_RESULTS) begin
                    push_frame(smp, chans);
                    made += chans;
                    advance_phase();
                end
                clear_phase();
            end

            if (made > 0) begin
                e = expected_frames[expected_frames.size() - 1];
                e.last_of_run = 1'b1;
                e.block_end = is_last;
                expected_frames[expected_frames.size() - 1] = e;
            end
        endfunction

        task check_result(t_frame_res got);
            t_frame_res want;
            if (expected_frames.size() == 0) begin
                report($sformatf("result with nothing expected: smp %0d ch %0d",
                                 got.smp, got.chan));
                return;
            end
            want = expected_frames.pop_front();
            if (got.smp !== want.smp || got.chan !== want.chan ||
                got.last_of_run !== want.last_of_run ||
                got.block_end !== want.block_end ||
                got.ratio_error !== want.ratio_error)
                report($sformatf({"got smp %0d ch %0d lor %b end %b err %b, ",
                                  "want smp %0d ch %0d lor %b end %b err %b"},
                                 got.smp, got.chan, got.last_of_run, got.block_end,
                                 got.ratio_error, want.smp, want.chan, want.last_of_run,
                                 want.block_end, want.ratio_error));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lir_in_if  #(.SAMPLE_BITS(16))            in_if ();
    lir_out_if #(.SAMPLE_BITS(16), .CH_W(2))  out_if ();

    resample_scoreboard sb = new();

    int items_sent;
    bit idle_en;
    int audio_rates[9] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000, 96000, 192000};

    linear_interp_resampler_core #(
        .SAMPLE_BITS  (16),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Write all three registers back to back; psel stays high between them
    task automatic cfg_write_all(input logic [RATE_W-1:0] ir, input logic [RATE_W-1:0] orr,
                                 input logic [CC_W-1:0] ch);
        logic [1:0]         idx[3];
        logic [PDATA_W-1:0] val[3];
        idx[0] = REG_IN_RATE;
        idx[1] = REG_OUT_RATE;
        idx[2] = REG_CHANNELS;
        val[0] = PDATA_W'(ir);
        val[1] = PDATA_W'(orr);
        val[2] = PDATA_W'(ch);
        for (int k = 0; k < 3; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx[k], 2'b00};
            pwdata  <= val[k];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            sb.apply_cfg(idx[k], val[k]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one sample request, with an optional gap first
    task automatic send_sample(input logic signed [15:0] smp, input bit is_last);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.sample_in   <= smp;
        in_if.last_sample <= is_last;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_sample(smp, is_last);
        items_sent++;
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_block(input int len, input bit closed);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(), closed && (i == len - 1));
    endtask

    // Drop valid, wait for every expected result, then let the core settle
    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    task automatic pick_config(output logic [RATE_W-1:0] ir, output logic [RATE_W-1:0] orr,
                               output logic [CC_W-1:0] ch);
        int sel;
        int lim;
        sel = $urandom_range(0, 11);
        if (sel <= 6) begin
            ir  = RATE_W'(audio_rates[$urandom_range(0, 8)]);
            orr = RATE_W'(audio_rates[$urandom_range(0, 8)]);
        end else if (sel == 7) begin
            ir  = RATE_W'($urandom_range(1, RATE_MAX));
            lim = int'(ir) * MAX_UPSAMPLE;
            if (lim > RATE_MAX)
                lim = RATE_MAX;
            orr = RATE_W'($urandom_range(1, lim));
        end else if (sel == 8) begin
            // exact upsampling limit
            ir  = RATE_W'($urandom_range(1, 24000));
            orr = RATE_W'(int'(ir) * MAX_UPSAMPLE);
        end else if (sel == 9) begin
            // deep downsampling, results are rare
            ir  = ($urandom_range(0, 1) != 0) ? RATE_W'(RATE_MAX) : RATE_W'(192000);
            orr = RATE_W'($urandom_range(1, 64));
        end else if (sel == 10) begin
            // just past the upsampling limit
            ir  = RATE_W'($urandom_range(1, 30000));
            orr = RATE_W'(int'(ir) * MAX_UPSAMPLE + int'($urandom_range(1, 64)));
        end else if ($urandom_range(0, 1) != 0) begin
            ir  = '0;
            orr = RATE_W'(audio_rates[$urandom_range(0, 8)]);
        end else begin
            ir  = RATE_W'(audio_rates[$urandom_range(0, 8)]);
            orr = '0;
        end
        ch = ($urandom_range(0, 4) == 0) ? CC_W'($urandom_range(0, 7))
                                         : CC_W'($urandom_range(1, 4));
    endtask

    // Result side: check each accepted result, stall in random bursts
    initial begin : result_sink
        t_frame_res got;
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.smp         = out_if.sample_out;
                got.chan        = out_if.channel_index;
                got.last_of_run = out_if.last_of_run;
                got.block_end   = out_if.block_end;
                got.ratio_error = out_if.ratio_error;
                sb.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // End the run when nothing has moved for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("linear_interp_resampler_core: mismatch");
        $finish;
    end

    // Main sequence: reset, directed phases, random phases, final check
    initial begin : main_seq
        logic [RATE_W-1:0] ir;
        logic [RATE_W-1:0] orr;
        logic [CC_W-1:0]   ch;
        int nblk;
        int len;
        items_sent = 0;
        idle_en = 1'b1;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.sample_in <= '0;
        in_if.last_sample <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset rates, 3x upsampling across full-scale steps
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);

        // Exact 8x with four channels fills the result cap on the last sample
        settle();
        cfg_write_all(18'd1, 18'd8, 3'd4);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);

        // Deep downsampling, channel count zero; each block yields a single frame
        settle();
        cfg_write_all(18'd192000, 18'd1, 3'd0);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd200, 1'b1);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd8, 1'b0);
        send_sample(16'sd9, 1'b1);

        // Ratio just past 8x, channel count above the maximum
        settle();
        cfg_write_all(18'd1000, 18'd8001, 3'd7);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd6, 1'b1);

        // Zero input rate, then zero output rate
        settle();
        cfg_write_all(18'd0, 18'd48000, 3'd2);
        send_sample(16'sd1, 1'b1);
        settle();
        cfg_write_all(18'd48000, 18'd0, 3'd2);
        send_sample(-16'sd5, 1'b0);

        // Leave a block open, then shrink out_rate so the remainder folds
        settle();
        cfg_write_all(18'd44100, 18'd192000, 3'd2);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd3000, 1'b0);
        send_sample(16'sd12345, 1'b0);
        settle();
        cfg_write_all(18'd44100, 18'd8000, 3'd2);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);

        // Random phases: mostly complete blocks, some left open across a change
        while (items_sent < TOTAL_ITEMS) begin
            settle();
            idle_en = (items_sent < TOTAL_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            pick_config(ir, orr, ch);
            cfg_write_all(ir, orr, ch);
            nblk = $urandom_range(1, 3);
            for (int b = 0; b < nblk; b++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                run_block(len, !((b == nblk - 1) && ($urandom_range(0, 3) == 0)));
            end
        end

        settle();
        if (sb.errors == 0 && sb.expected_frames.size() == 0)
            $display("linear_interp_resampler_core: match");
        else
            $display("linear_interp_resampler_core: mismatch");
        $finish;
    end

endmodule
